FILE: hw/rtl/port_set_response_checker_macros.svh
// Assertion macros used by the port-set response checker RTL.
`ifndef PORT_SET_RESPONSE_CHECKER_MACROS_SVH
`define PORT_SET_RESPONSE_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Combinational property checked at every rising clock edge outside reset.
`define PSRC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Property that holds on the cycle after its trigger.
`define PSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSRC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define PSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/psrc_pkg.sv
// Constants, codes and field widths of the port-set response checker.
package psrc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXPECTED_OPCODE    = 2'd0;
    localparam logic [1:0] CFG_INITIAL_RETRY_WAIT = 2'd1;
    localparam logic [1:0] CFG_MAX_RETRY_WAIT     = 2'd2;

    // Register reset values.
    localparam logic [6:0]  RST_EXPECTED_OPCODE = 7'd0;
    localparam logic [15:0] RST_INITIAL_WAIT    = 16'd3;
    localparam logic [15:0] RST_MAX_WAIT        = 16'd1024;
    localparam logic [31:0] DEFAULT_LIFETIME    = 32'd86400;

    // Datagram length limits.
    localparam logic [15:0] LEN_MIN = 16'd3;
    localparam logic [15:0] LEN_MAX = 16'd1024;

    // Epoch agreement slack; the proportional part is a shift by four.
    localparam logic [31:0] EPOCH_SLACK = 32'd2;
    localparam int          EPOCH_SHIFT = 4;

    // Operation selector on the input tuser.
    localparam logic OP_RESPONSE = 1'b0;
    localparam logic OP_TIMEOUT  = 1'b1;

    // Verdict codes.
    typedef logic [2:0] t_verdict;
    localparam t_verdict V_OK         = 3'd0;
    localparam t_verdict V_DROP       = 3'd1;
    localparam t_verdict V_EPOCH      = 3'd2;
    localparam t_verdict V_SERVER_ERR = 3'd3;
    localparam t_verdict V_TIMEOUT    = 3'd4;

    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 120;

endpackage

FILE: hw/rtl/port_set_response_checker.sv
// Port-set mapping response checker: top level.
//
// Usage:
//   The slave stream carries one beat per event. tuser selects the event:
//   0 a parsed response header, 1 a receive timeout. The master stream
//   returns one result beat for every input beat, in order, with the
//   verdict in tuser and the stored mapping registers in tdata.
//   Configuration (expected opcode, initial and maximum retry wait) goes in through a
//   plain write port, by the user only while the block is idle; it is not enforced.
// Pipeline and throughput:
//   A beat accepted into the input register is checked by the
//   combinational logic and loaded into the result register once that
//   register is free or drains. One beat is taken every cycle while the
//   receiver does not stall; the rate is set by the single update of the
//   epoch and retry state.
// Reset and stalls:
//   Synchronous active-low reset clears both stages, holds tready low and
//   loads the defaults (lifetime 86400, retry wait 3, epoch state unset).
//   While the receiver stalls, the result is held and the input register
//   still takes one more beat before tready falls.
module port_set_response_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    // Slave stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: packet_length(16), response_flag(1), opcode(7),
    // result_code(8), granted_lifetime(32), server_epoch(32),
    // client_time(32), port_mask(16), port_value(16), external_ipv4(32)
    input  logic [psrc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: operation(1)
    input  logic         s_axis_tuser,
    // Master stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: error_code(8), lifetime(32), first_port(16),
    // last_port(16), assigned_ipv4(32), retry_wait(16)
    output logic [psrc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: verdict(3)
    output logic [2:0]   m_axis_tuser
);

`include "port_set_response_checker_macros.svh"

    // Configuration registers.
    logic [6:0]  r_exp_opcode;
    logic [15:0] r_init_wait;
    logic [15:0] r_max_wait;

    // Input stage.
    logic                           r_in_valid;
    logic [psrc_pkg::IN_DATA_W-1:0] r_in_data;
    logic                           r_in_op;

    // Mapping and epoch state.
    logic [31:0] r_lifetime, n_lifetime;
    logic [31:0] r_client_now, n_client_now;
    logic [31:0] r_client_before, n_client_before;
    logic [31:0] r_server_before, n_server_before;
    logic [15:0] r_start, n_start;
    logic [15:0] r_end, n_end;
    logic [31:0] r_ipv4, n_ipv4;
    logic [15:0] r_wait, n_wait;

    // Output stage.
    logic                 r_out_valid;
    psrc_pkg::t_verdict   r_out_verdict;
    psrc_pkg::t_verdict   n_verdict;
    logic [7:0]           r_out_err, n_err;

    logic adv;

    // Fields of the registered beat.
    logic [15:0] f_len;
    logic        f_rflag;
    logic [6:0]  f_opcode;
    logic [7:0]  f_rc;
    logic [31:0] f_life;
    logic [31:0] f_srv;
    logic [31:0] f_clk;
    logic [15:0] f_mask;
    logic [15:0] f_value;
    logic [31:0] f_ipv4;

    assign f_len    = r_in_data[15:0];
    assign f_rflag  = r_in_data[16];
    assign f_opcode = r_in_data[23:17];
    assign f_rc     = r_in_data[31:24];
    assign f_life   = r_in_data[63:32];
    assign f_srv    = r_in_data[95:64];
    assign f_clk    = r_in_data[127:96];
    assign f_mask   = r_in_data[143:128];
    assign f_value  = r_in_data[159:144];
    assign f_ipv4   = r_in_data[191:160];

    // The input stage moves on when the result register is free or drains.
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || adv);

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_opcode <= psrc_pkg::RST_EXPECTED_OPCODE;
            r_init_wait  <= psrc_pkg::RST_INITIAL_WAIT;
            r_max_wait   <= psrc_pkg::RST_MAX_WAIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                psrc_pkg::CFG_EXPECTED_OPCODE:    r_exp_opcode <= i_cfg_wdata[6:0];
                psrc_pkg::CFG_INITIAL_RETRY_WAIT: r_init_wait  <= i_cfg_wdata;
                psrc_pkg::CFG_MAX_RETRY_WAIT:     r_max_wait   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_op   <= s_axis_tuser;
        end
    end

    // Checking logic for the registered beat.
    always_comb begin
        logic        len_bad;
        logic [16:0] dbl;
        logic [31:0] cb_eff;
        logic [31:0] cd;
        logic [31:0] sd;
        logic        disagree;

        n_lifetime      = r_lifetime;
        n_client_now    = r_client_now;
        n_client_before = r_client_before;
        n_server_before = r_server_before;
        n_start         = r_start;
        n_end           = r_end;
        n_ipv4          = r_ipv4;
        n_wait          = r_wait;
        n_verdict       = psrc_pkg::V_OK;
        n_err           = 8'd0;

        len_bad = (f_len < psrc_pkg::LEN_MIN) || (f_len > psrc_pkg::LEN_MAX) ||
                  (f_len[1:0] != 2'b00);
        dbl     = {r_wait, 1'b0};

        // A first client time also sets the earlier sample.
        cb_eff   = (r_client_now == 32'd0) ? f_clk : r_client_before;
        cd       = f_clk - cb_eff;
        sd       = f_srv - r_server_before;
        disagree = ((cd + psrc_pkg::EPOCH_SLACK) < (sd - (sd >> psrc_pkg::EPOCH_SHIFT))) ||
                   ((sd + psrc_pkg::EPOCH_SLACK) < (cd - (cd >> psrc_pkg::EPOCH_SHIFT)));

        if (r_in_op == psrc_pkg::OP_TIMEOUT) begin
            // Double the wait, capped at the maximum.
            n_wait    = (dbl > {1'b0, r_max_wait}) ? r_max_wait : dbl[15:0];
            n_verdict = psrc_pkg::V_TIMEOUT;
        end else begin
            n_wait = r_init_wait;
            if (len_bad || !f_rflag || (f_opcode != r_exp_opcode)) begin
                n_verdict = psrc_pkg::V_DROP;
            end else begin
                n_lifetime   = f_life;
                n_client_now = f_clk;
                if (r_server_before == 32'd0) begin
                    // First server epoch: record it and skip the check.
                    n_server_before = f_srv;
                    n_client_before = cb_eff;
                end else begin
                    n_client_before = f_clk;
                    n_server_before = f_srv;
                    if ((r_server_before > f_srv) || disagree) begin
                        n_verdict = psrc_pkg::V_EPOCH;
                    end
                end
                if (n_verdict == psrc_pkg::V_OK) begin
                    if (f_rc != 8'd0) begin
                        n_verdict = psrc_pkg::V_SERVER_ERR;
                        n_err     = f_rc;
                    end else begin
                        // Range end is value plus two's complement of mask minus one.
                        n_ipv4  = f_ipv4;
                        n_start = f_value;
                        n_end   = f_value + ~f_mask;
                    end
                end
            end
        end
    end

    // State update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime      <= psrc_pkg::DEFAULT_LIFETIME;
            r_client_now    <= 32'd0;
            r_client_before <= 32'd0;
            r_server_before <= 32'd0;
            r_start         <= 16'd0;
            r_end           <= 16'd0;
            r_ipv4          <= 32'd0;
            r_wait          <= psrc_pkg::RST_INITIAL_WAIT;
        end else if (adv) begin
            r_lifetime      <= n_lifetime;
            r_client_now    <= n_client_now;
            r_client_before <= n_client_before;
            r_server_before <= n_server_before;
            r_start         <= n_start;
            r_end           <= n_end;
            r_ipv4          <= n_ipv4;
            r_wait          <= n_wait;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_verdict <= n_verdict;
            r_out_err     <= n_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_verdict;
    assign m_axis_tdata  = {r_wait, r_ipv4, r_end, r_start, r_lifetime, r_out_err};

    // A server code is only reported with the server error verdict.
    `PSRC_ASSERT_ALWAYS(a_err_only_on_server_error, i_clk, i_rst_n,
        !r_out_valid || (r_out_err == 8'd0) || (r_out_verdict == psrc_pkg::V_SERVER_ERR),
        "error code set without server error verdict")

    // A timeout never leaves the wait above the cap.
    `PSRC_ASSERT_NEXT(a_wait_capped, i_clk, i_rst_n,
        adv && (r_in_op == psrc_pkg::OP_TIMEOUT),
        r_wait <= $past(r_max_wait),
        "retry wait exceeds maximum after timeout")

    // Any response reloads the initial wait.
    `PSRC_ASSERT_NEXT(a_response_reloads_wait, i_clk, i_rst_n,
        adv && (r_in_op == psrc_pkg::OP_RESPONSE),
        r_wait == $past(r_init_wait),
        "retry wait not reloaded on response")

    // A beat held in the input stage is never lost while the output stalls.
    `PSRC_ASSERT_NEXT(a_input_held, i_clk, i_rst_n,
        r_in_valid && !adv,
        r_in_valid && r_out_valid,
        "input beat lost during stall")

endmodule
